// File: src/tcce_pkg.sv
package tcce_pkg;

  // Input request and result payloads
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [12:0] cell_addr;
    logic        last_byte;
  } tcce_in_t;

  typedef struct packed {
    logic [12:0] cursor_index;
    logic [12:0] start_index;
    logic [6:0]  column;
    logic [6:0]  row;
    logic [15:0] cell_data;
  } tcce_out_t;

  // Request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Console control bytes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // Blank cell: space on light gray
  localparam logic [15:0] ERASE_CELL = 16'h0720;

  localparam int COL_W  = 7;
  localparam int QDEPTH = 2;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_READ,
    CMD_CLEAR,
    CMD_SETTLE,
    CMD_BACK,
    CMD_LINE,
    CMD_RETURN,
    CMD_DELETE,
    CMD_PRINT
  } tcce_kind_t;

  typedef struct packed {
    tcce_kind_t  kind;
    logic [7:0]  ch;
    logic [12:0] addr;
  } tcce_cmd_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD_TAKE,
    ST_XY_MUL,
    ST_XY_FIX,
    ST_CHK,
    ST_SCROLL,
    ST_CP_RD,
    ST_CP_WR,
    ST_ZERO,
    ST_WRAP_FIX,
    ST_DL_RD,
    ST_DL_EV,
    ST_RESULT
  } tcce_state_t;

endpackage

// File: src/tcce_front.sv
module tcce_front
  import tcce_pkg::*;
(
  input  logic      in_valid,
  input  tcce_in_t  in_data,
  input  logic      q_full,
  input  logic      init_busy,
  output logic      in_stall,
  output logic      push,
  output tcce_cmd_t cmd
);

  // Hold off requests while the queue is full or the memory clear after reset runs
  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  // Classify the request into a command for the back end
  always_comb begin
    cmd.ch   = in_data.ch;
    cmd.addr = in_data.cell_addr;
    cmd.kind = CMD_NOP;
    unique case (in_data.op)
      OP_WRITE: begin
        unique case (in_data.ch) inside
          CH_NUL: cmd.kind = CMD_SETTLE;
          CH_ENQ, CH_BEL, CH_TAB, CH_VT, CH_FF: cmd.kind = CMD_NOP;
          CH_BS:  cmd.kind = CMD_BACK;
          CH_LF:  cmd.kind = CMD_LINE;
          CH_CR:  cmd.kind = CMD_RETURN;
          CH_DEL: cmd.kind = CMD_DELETE;
          default: cmd.kind = CMD_PRINT;
        endcase
      end
      OP_READ:  cmd.kind = CMD_READ;
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      default:  cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// File: src/tcce_fifo.sv
module tcce_fifo
  import tcce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcce_cmd_t push_data,
  input  logic      pop,
  output logic      pop_valid,
  output tcce_cmd_t pop_data,
  output logic      full
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QDEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QDEPTH - 1);

  tcce_cmd_t       slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign pop_valid = count_r != '0;
  assign full      = count_r == DEPTH_C;
  assign pop_data  = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/tcce_back.sv
module tcce_back
  import tcce_pkg::*;
#(
  parameter int COLS  = 80,
  parameter int ROWS  = 25,
  parameter int CELLS = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  tcce_cmd_t  cmd,
  output logic       cmd_pop,
  input  logic [7:0] attr,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output tcce_out_t  out_data
);

  localparam int AW    = $clog2(CELLS);
  localparam int XW    = AW + 1;
  localparam int IW    = AW + 3;
  localparam int K     = IW + 8;
  localparam int PW    = IW + K;
  localparam int GW    = $clog2(ROWS + 3);
  localparam int SCR_I = (ROWS * COLS > CELLS) ? CELLS : ROWS * COLS;

  localparam logic [IW-1:0]    CELLS_W    = IW'(CELLS);
  localparam logic [IW-1:0]    COLS_W     = IW'(COLS);
  localparam logic [IW-1:0]    WRAP_AT    = IW'(CELLS - COLS);
  localparam logic [IW-1:0]    ROWS_M1    = IW'(ROWS - 1);
  localparam logic [GW-1:0]    LIMIT_G    = GW'(ROWS + 2);
  localparam logic [XW-1:0]    SCR_LAST   = XW'(SCR_I - 1);
  localparam logic [XW-1:0]    CELLS_LAST = XW'(CELLS - 1);
  localparam logic [COL_W-1:0] COLS_M1_C  = COL_W'(COLS - 1);
  localparam logic [PW-1:0]    RECIP      = PW'((2 ** K) / COLS);
  localparam bit               SCR_FULL   = (SCR_I == CELLS);

  tcce_state_t      state_r, state_nxt;
  tcce_kind_t       kind_r, kind_nxt;
  logic [IW-1:0]    start_r, start_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [IW-1:0]    row_r, row_nxt;
  logic [GW-1:0]    guard_r, guard_nxt;
  logic             lf_pre_r, lf_pre_nxt;
  logic             report_r, report_nxt;
  logic [XW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [COL_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [15:0]      data_r, data_nxt;
  logic             out_valid_r, out_valid_nxt;
  tcce_out_t        out_r, out_nxt;

  // Video memory and its registered read port
  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_q;
  logic          rd_zero_r, rd_zero_nxt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic [IW-1:0] span, quot0, rem0, start_step, col_zero_cell, cp_src, dl_src;
  logic          rem_fix, chk_cond, can_scroll, wrap_now, dl_hit, out_free;
  logic [15:0]   rd_val;

  assign span          = (cur_r > start_r) ? cur_r - start_r : '0;
  assign quot0         = prod_r[PW-1:K];
  assign rem0          = span - quot0 * COLS_W;
  assign rem_fix       = rem0 >= COLS_W;
  assign chk_cond      = lf_pre_r ? (row_r >= ROWS_M1) : (row_r > ROWS_M1);
  assign can_scroll    = chk_cond && (guard_r < LIMIT_G);
  assign start_step    = start_r + COLS_W;
  assign wrap_now      = cur_r > WRAP_AT;
  assign col_zero_cell = start_r + row_r * COLS_W;
  assign cp_src        = start_r + IW'(idx_r);
  assign dl_src        = ptr_r + 1'b1;
  assign rd_val        = rd_zero_r ? 16'h0000 : rd_q;
  assign dl_hit        = (cnt_r != '0) && (rd_val[7:0] != 8'h00);
  assign out_free      = !out_valid_r || !out_stall;

  assign init_busy = (state_r == ST_CLR) && !report_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (idx_r == CELLS_LAST) state_nxt = report_r ? ST_RESULT : ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_READ:   state_nxt = ST_RD_TAKE;
            CMD_CLEAR:  state_nxt = ST_CLR;
            CMD_SETTLE, CMD_BACK, CMD_PRINT: state_nxt = ST_XY_MUL;
            CMD_LINE:   state_nxt = ST_CHK;
            CMD_DELETE: state_nxt = ST_DL_RD;
            default:    state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_RD_TAKE: state_nxt = ST_RESULT;
      ST_XY_MUL:  state_nxt = ST_XY_FIX;
      ST_XY_FIX:  state_nxt = ST_CHK;
      ST_CHK: begin
        if (can_scroll) begin
          state_nxt = ST_SCROLL;
        end else if (lf_pre_r) begin
          state_nxt = ST_XY_MUL;
        end else if (kind_r == CMD_BACK) begin
          state_nxt = ST_DL_RD;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_SCROLL: begin
        if (wrap_now) begin
          state_nxt = ST_CP_RD;
        end else if (cur_r < start_step) begin
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_XY_MUL;
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        if (idx_r == SCR_LAST) state_nxt = SCR_FULL ? ST_WRAP_FIX : ST_ZERO;
        else state_nxt = ST_CP_RD;
      end
      ST_ZERO: begin
        if (idx_r == CELLS_LAST) state_nxt = ST_WRAP_FIX;
      end
      ST_WRAP_FIX: state_nxt = ST_XY_MUL;
      ST_DL_RD:    state_nxt = ST_DL_EV;
      ST_DL_EV: begin
        state_nxt = dl_hit ? ST_DL_RD : ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory port and result register
  always_comb begin
    kind_nxt      = kind_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    guard_nxt     = guard_r;
    lf_pre_nxt    = lf_pre_r;
    report_nxt    = report_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    data_nxt      = data_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    rd_zero_nxt   = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == CELLS_LAST) begin
          report_nxt = 1'b0;
          if (report_r) begin
            start_nxt = '0;
            cur_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
          end
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          kind_nxt = cmd.kind;
          data_nxt = '0;
          unique case (cmd.kind)
            CMD_READ: begin
              mem_raddr   = AW'(cmd.addr);
              rd_zero_nxt = IW'(cmd.addr) >= CELLS_W;
            end
            CMD_CLEAR: begin
              idx_nxt    = '0;
              report_nxt = 1'b1;
            end
            CMD_SETTLE: begin
              lf_pre_nxt = 1'b0;
              guard_nxt  = '0;
            end
            CMD_BACK: begin
              if (cur_r > start_r) cur_nxt = cur_r - 1'b1;
              lf_pre_nxt = 1'b0;
              guard_nxt  = '0;
            end
            CMD_LINE: begin
              lf_pre_nxt = 1'b1;
              guard_nxt  = '0;
            end
            CMD_RETURN: begin
              col_nxt = '0;
              cur_nxt = col_zero_cell;
            end
            CMD_DELETE: begin
              cnt_nxt = COLS_M1_C - col_r;
              ptr_nxt = cur_r;
            end
            CMD_PRINT: begin
              if (cur_r < CELLS_W) begin
                mem_we    = 1'b1;
                mem_waddr = cur_r[AW-1:0];
                mem_wdata = {attr, cmd.ch};
              end
              cur_nxt    = cur_r + 1'b1;
              lf_pre_nxt = 1'b0;
              guard_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD_TAKE: data_nxt = rd_val;
      ST_XY_MUL:  prod_nxt = PW'(span) * RECIP;
      ST_XY_FIX: begin
        // Correct the reciprocal estimate by at most one
        if (rem_fix) begin
          row_nxt = quot0 + 1'b1;
          col_nxt = COL_W'(rem0 - COLS_W);
        end else begin
          row_nxt = quot0;
          col_nxt = COL_W'(rem0);
        end
      end
      ST_CHK: begin
        if (can_scroll) begin
          guard_nxt = guard_r + 1'b1;
        end else if (lf_pre_r) begin
          cur_nxt    = cur_r + COLS_W;
          lf_pre_nxt = 1'b0;
          guard_nxt  = '0;
        end else if (kind_r == CMD_BACK) begin
          cnt_nxt = COLS_M1_C - col_r;
          ptr_nxt = cur_r;
        end else if (kind_r == CMD_LINE) begin
          col_nxt = '0;
          cur_nxt = col_zero_cell;
        end
      end
      ST_SCROLL: begin
        if (wrap_now) begin
          idx_nxt = '0;
        end else begin
          start_nxt = start_step;
          if (cur_r < start_step) begin
            col_nxt = '0;
            row_nxt = '0;
            cur_nxt = start_step;
          end
        end
      end
      ST_CP_RD: begin
        mem_raddr   = cp_src[AW-1:0];
        rd_zero_nxt = cp_src >= CELLS_W;
      end
      ST_CP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rd_val;
        idx_nxt   = idx_r + 1'b1;
      end
      ST_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + 1'b1;
      end
      ST_WRAP_FIX: begin
        cur_nxt   = (cur_r >= start_r) ? cur_r - start_r : '0;
        start_nxt = '0;
      end
      ST_DL_RD: begin
        mem_raddr   = dl_src[AW-1:0];
        rd_zero_nxt = dl_src >= CELLS_W;
      end
      ST_DL_EV: begin
        // Shift the next cell left, or drop a blank at the end
        if (ptr_r < CELLS_W) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_r[AW-1:0];
          mem_wdata = dl_hit ? rd_val : ERASE_CELL;
        end
        if (dl_hit) begin
          ptr_nxt = dl_src;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.cursor_index = cur_r[12:0];
          out_nxt.start_index  = start_r[12:0];
          out_nxt.column       = col_r;
          out_nxt.row          = row_r[6:0];
          out_nxt.cell_data    = data_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      report_r    <= 1'b0;
      idx_r       <= '0;
      start_r     <= '0;
      cur_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      report_r    <= report_nxt;
      idx_r       <= idx_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    guard_r   <= guard_nxt;
    lf_pre_r  <= lf_pre_nxt;
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    data_r    <= data_nxt;
    out_r     <= out_nxt;
    rd_zero_r <= rd_zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

endmodule

// File: src/text_console_char_engine_core.sv
// Text console engine: keeps a video memory of 16-bit cells (character low,
// attribute high) plus the screen start and cursor, and reports the CRT
// cursor and start values for every request.
// Input channel in_valid/in_stall/in_data: one request per accepted edge;
// op write handles one console byte, op read returns one cell, op clear wipes
// the console. A two-entry queue sits between the decoder and the executor,
// so requests are taken while the executor works or a result waits.
// Result channel out_valid/out_stall/out_data: exactly one result per
// request, in order, held in an output register while out_stall is high.
// Executor: carriage return and unused codes go straight to the result; a
// read first takes the memory data; a printable byte is written, then its
// row and column come from a multiply and a fix step, with more steps per
// one-row scroll and per cell shifted by delete or backspace. A scroll near
// the end of memory copies the screen (a read and a write per cell) and
// zeroes the rest. Clear and the clear after reset write one cell per
// cycle through the video memory's single write port; in_stall stays high
// for the latter. cfg_we/cfg_data set the attribute byte, reset value 7.
module text_console_char_engine_core
  import tcce_pkg::*;
#(
  parameter int COLS  = 80,
  parameter int ROWS  = 25,
  parameter int CELLS = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcce_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tcce_out_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic       push, pop, q_valid, q_full, init_busy;
  tcce_cmd_t  push_cmd, pop_cmd;
  logic [7:0] attr_r;

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= 8'h07;
    end else if (cfg_we) begin
      attr_r <= cfg_data;
    end
  end

  tcce_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .init_busy (init_busy),
    .in_stall  (in_stall),
    .push      (push),
    .cmd       (push_cmd)
  );

  tcce_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (pop_cmd),
    .full      (q_full)
  );

  tcce_back #(
    .COLS  (COLS),
    .ROWS  (ROWS),
    .CELLS (CELLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .attr      (attr_r),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue never overflows and never pops empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("command popped from empty queue");

  // No request taken during the memory clear after reset
  a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> in_stall)
    else $error("request accepted during memory clear");

  // Reported column stays on screen
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.column) < COLS))
    else $error("column out of range");

endmodule
